// ----- design/msas_pkg.sv -----
// Package: shared types, constants and helpers of the mouse-to-stick smoother.
`timescale 1ns / 1ps
`default_nettype none

package msas_pkg;

  // Field and register widths
  localparam int FRAC_BITS   = 8;
  localparam int DELTA_WIDTH = 12;
  localparam int SENS_W      = 12;
  localparam int SENS_FRAC   = 8;
  localparam int SMOOTH_W    = 8;
  localparam int TIMEOUT_W   = 10;
  localparam int IDLE_W      = 11;
  localparam int STICK_W     = 16;
  localparam int CMD_W       = 2;
  localparam int VEL_W       = STICK_W + 1 + FRAC_BITS;

  // APB
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 5;
  localparam int REG_IDX_W   = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SENS_X  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SENS_Y  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INVERT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  // Register reset values
  localparam logic [SENS_W-1:0]    SENS_RST    = 12'd256;
  localparam logic [SMOOTH_W-1:0]  SMOOTH_RST  = 8'd128;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd100;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_MOVE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

  // Analog scaling
  localparam int SCALE_W = 7;
  localparam logic signed [SCALE_W:0] ANALOG_SCALE = 8'sd100;
  localparam int MAX_ANALOG = 32767;
  localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

  // Move datapath widths
  localparam int P1_W   = DELTA_WIDTH + SENS_W + 1;
  localparam int RAW_W  = P1_W + SCALE_W;
  localparam int SH_UP  = (FRAC_BITS >= SENS_FRAC) ? FRAC_BITS - SENS_FRAC : 0;
  localparam int SH_DN  = (FRAC_BITS <  SENS_FRAC) ? SENS_FRAC - FRAC_BITS : 0;
  localparam int IN_W   = RAW_W + SH_UP;
  localparam int WGT_W  = SMOOTH_W + 1;
  localparam int B_W    = IN_W + WGT_W + 1;
  localparam int OV_W   = VEL_W + WGT_W + 1;
  localparam int SUM_W  = ((B_W > OV_W) ? B_W : OV_W) + 1;
  localparam logic signed [SUM_W-1:0] VEL_LIM = SUM_W'(MAX_ANALOG) <<< FRAC_BITS;

  // Decay datapath: v*85/100 = floor(floor(v*85/4)/25)
  localparam int DECAY_W = 7;
  localparam logic [DECAY_W-1:0] DECAY_NUM = 7'd85;
  localparam int M85_W   = VEL_W + DECAY_W;
  localparam int M4_W    = M85_W - 2;
  localparam int DIV_K   = M4_W + 5;
  localparam int RECIP_W = M4_W + 1;
  localparam logic [RECIP_W-1:0] DIV25_RECIP = RECIP_W'((64'd1 << DIV_K) / 64'd25);
  localparam logic [M4_W-1:0] DIV25 = M4_W'(25);

  // Lane sequencing
  localparam int LANE_STEPS = 4;
  localparam int STEP_W     = $clog2(LANE_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LANE_STEPS - 1);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MOVE,
    OP_DECAY
  } lane_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    lane_op_e            op;
    logic                run;
    logic [STEP_W-1:0]   step;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0]              cmd;
    logic signed [DELTA_WIDTH-1:0] delta_x;
    logic signed [DELTA_WIDTH-1:0] delta_y;
  } in_word_t;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic                      active;
  } out_word_t;

  // Move from sensitivity fraction bits to FRAC_BITS, truncating toward zero
  function automatic logic signed [IN_W-1:0] scale_in(input logic signed [RAW_W-1:0] raw);
    logic signed [RAW_W:0] ext;
    logic signed [RAW_W:0] bias;
    logic signed [RAW_W:0] dn;
    ext  = (RAW_W+1)'(raw);
    bias = raw[RAW_W-1] ? (RAW_W+1)'((1 << SH_DN) - 1) : '0;
    dn   = (ext + bias) >>> SH_DN;
    return IN_W'(dn) <<< SH_UP;
  endfunction

endpackage

`default_nettype wire

// ----- design/msas_lane.sv -----
// One axis lane: four-step multiply sequence for the smoothing blend and the idle decay.
`timescale 1ns / 1ps
`default_nettype none

module msas_lane (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire msas_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic signed [msas_pkg::DELTA_WIDTH-1:0] delta_i,
  input  wire logic [msas_pkg::SENS_W-1:0]        sens_i,
  input  wire logic [msas_pkg::SMOOTH_W-1:0]      smooth_i,
  input  wire logic                               negate_i,
  output logic signed [msas_pkg::VEL_W-1:0]       vel_o
);
  import msas_pkg::*;

  logic signed [VEL_W-1:0] vel_q, vel_d;

  // move path
  logic signed [P1_W-1:0]  p1_q, p1_d;
  logic signed [IN_W-1:0]  in_q, in_d;
  logic signed [OV_W-1:0]  ov_q, ov_d;
  logic signed [B_W-1:0]   b_q, b_d;
  logic signed [RAW_W-1:0] raw;
  logic signed [IN_W-1:0]  scaled;
  logic [WGT_W-1:0]        wgt;
  logic signed [SUM_W-1:0] sum, sum_b, sum_t;
  logic signed [VEL_W-1:0] blend;

  // decay path
  logic [VEL_W-1:0]           mag;
  logic [M85_W-1:0]           m85_q, m85_d;
  logic [M4_W-1:0]            m4_q, m4;
  logic [M4_W-1:0]            q0_q, q0_d;
  logic [M4_W+RECIP_W-1:0]    qprod;
  logic [M4_W-1:0]            rem, qfix;
  logic signed [VEL_W-1:0]    dres_q, dres_d;

  logic do_move, do_decay;

  assign do_move  = ctrl_i.run && (ctrl_i.op == OP_MOVE);
  assign do_decay = ctrl_i.run && (ctrl_i.op == OP_DECAY);

  // step 0
  assign p1_d  = P1_W'(delta_i) * P1_W'(signed'({1'b0, sens_i}));
  assign mag   = vel_q[VEL_W-1] ? VEL_W'(-vel_q) : VEL_W'(vel_q);
  assign m85_d = M85_W'(mag) * M85_W'(DECAY_NUM);

  // step 1
  assign raw    = RAW_W'(p1_q) * RAW_W'(ANALOG_SCALE);
  assign scaled = scale_in(raw);
  assign in_d   = negate_i ? -scaled : scaled;
  assign ov_d   = OV_W'(vel_q) * OV_W'(signed'({1'b0, smooth_i}));
  assign m4     = M4_W'(m85_q >> 2);
  assign qprod  = (M4_W+RECIP_W)'(m4) * (M4_W+RECIP_W)'(DIV25_RECIP);
  assign q0_d   = M4_W'(qprod >> DIV_K);

  // step 2
  assign wgt  = {1'b1, {SMOOTH_W{1'b0}}} - {1'b0, smooth_i};
  assign b_d  = B_W'(in_q) * B_W'(signed'({1'b0, wgt}));
  assign rem  = m4_q - M4_W'(q0_q * DIV25);
  assign qfix = (rem >= DIV25) ? q0_q + M4_W'(1) : q0_q;
  always_comb begin
    if (qfix < (M4_W'(1) << FRAC_BITS)) begin
      dres_d = '0;
    end else if (vel_q[VEL_W-1]) begin
      dres_d = -VEL_W'(qfix);
    end else begin
      dres_d = VEL_W'(qfix);
    end
  end

  // step 3: /256 toward zero, then clamp
  assign sum   = SUM_W'(ov_q) + SUM_W'(b_q);
  assign sum_b = sum + (sum[SUM_W-1] ? SUM_W'((1 << SMOOTH_W) - 1) : SUM_W'(0));
  assign sum_t = sum_b >>> SMOOTH_W;
  always_comb begin
    if (sum_t > VEL_LIM) begin
      blend = VEL_W'(VEL_LIM);
    end else if (sum_t < -VEL_LIM) begin
      blend = VEL_W'(-VEL_LIM);
    end else begin
      blend = VEL_W'(sum_t);
    end
  end

  always_comb begin
    vel_d = vel_q;
    if (ctrl_i.run && ctrl_i.step == STEP_LAST) begin
      unique case (ctrl_i.op)
        OP_MOVE:  vel_d = blend;
        OP_DECAY: vel_d = dres_q;
        default:  vel_d = vel_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
    end else begin
      vel_q <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_move && ctrl_i.step == STEP_W'(0)) begin
      p1_q <= p1_d;
    end
    if (do_move && ctrl_i.step == STEP_W'(1)) begin
      in_q <= in_d;
      ov_q <= ov_d;
    end
    if (do_move && ctrl_i.step == STEP_W'(2)) begin
      b_q <= b_d;
    end
    if (do_decay && ctrl_i.step == STEP_W'(0)) begin
      m85_q <= m85_d;
    end
    if (do_decay && ctrl_i.step == STEP_W'(1)) begin
      q0_q <= q0_d;
      m4_q <= m4;
    end
    if (do_decay && ctrl_i.step == STEP_W'(2)) begin
      dres_q <= dres_d;
    end
  end

  assign vel_o = vel_q;

endmodule

`default_nettype wire

// ----- design/msas_merge.sv -----
// Merge stage: joins both lane velocities and the active flag into the output register.
`timescale 1ns / 1ps
`default_nettype none

module msas_merge (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               load_i,
  input  wire logic signed [msas_pkg::VEL_W-1:0] vel_x_i,
  input  wire logic signed [msas_pkg::VEL_W-1:0] vel_y_i,
  input  wire                               active_i,
  input  wire                               out_ready_i,
  output logic                              out_valid_o,
  output msas_pkg::out_word_t               out_word_o,
  output logic                              free_o
);
  import msas_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;

  // truncate toward zero to whole units
  function automatic logic signed [STICK_W-1:0] to_stick(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W:0] b;
    b = (VEL_W+1)'(v) + (v[VEL_W-1] ? (VEL_W+1)'((1 << FRAC_BITS) - 1) : '0);
    return STICK_W'(b >>> FRAC_BITS);
  endfunction

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    word_d.stick_x = to_stick(vel_x_i);
    word_d.stick_y = to_stick(vel_y_i);
    word_d.active  = active_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

// ----- design/mouse_to_analog_stick_smoother.sv -----
// Top level: mouse-to-analog-stick smoother with APB registers, idle tracking and two axis lanes.
//
//   channel   direction  handshake                    word
//   input     in         in_valid_i / in_ready_o      in_word_t  {cmd, delta_x, delta_y}
//   output    out        out_valid_o / out_ready_i    out_word_t {stick_x, stick_y, active}
//   config    in         psel/penable/pwrite, pready  5 regs at paddr 4*i, 32-bit data
//
// A move with motion or a poll past the idle timeout runs: accept, four lane steps (the
//   multiply sequence inside each lane sets the step count), then a load into the output reg once it is free.
// Ticks, zero moves, polls inside the timeout and unused codes skip the lanes: accept, then load.
// Reset (rst_ni, async, low) zeroes velocities, idle count and active; regs take defaults.
// The next word is accepted while a finished result sits in the output register; a new
//   result waits in the done state until that register is taken.
`timescale 1ns / 1ps
`default_nettype none

module mouse_to_analog_stick_smoother (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire msas_pkg::in_word_t            in_word_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output msas_pkg::out_word_t                out_word_o,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire logic [msas_pkg::APB_AW-1:0]   paddr,
  input  wire logic [msas_pkg::APB_DW-1:0]   pwdata,
  output logic [msas_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import msas_pkg::*;

  // Configuration registers
  logic [SENS_W-1:0]    sens_x_q, sens_y_q;
  logic [SMOOTH_W-1:0]  smooth_q;
  logic                 invert_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_x_q  <= SENS_RST;
      sens_y_q  <= SENS_RST;
      smooth_q  <= SMOOTH_RST;
      invert_q  <= 1'b0;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SENS_X:  sens_x_q  <= pwdata[SENS_W-1:0];
        REG_SENS_Y:  sens_y_q  <= pwdata[SENS_W-1:0];
        REG_SMOOTH:  smooth_q  <= pwdata[SMOOTH_W-1:0];
        REG_INVERT:  invert_q  <= pwdata[0];
        REG_TIMEOUT: timeout_q <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SENS_X:  prdata = APB_DW'(sens_x_q);
      REG_SENS_Y:  prdata = APB_DW'(sens_y_q);
      REG_SMOOTH:  prdata = APB_DW'(smooth_q);
      REG_INVERT:  prdata = APB_DW'(invert_q);
      REG_TIMEOUT: prdata = APB_DW'(timeout_q);
      default:     prdata = '0;
    endcase
  end

  // Control
  ctrl_state_e               state_q, state_d;
  logic [STEP_W-1:0]         step_q, step_d;
  lane_op_e                  op_q, op_d;
  logic signed [DELTA_WIDTH-1:0] dx_q, dy_q;
  logic [IDLE_W-1:0]         idle_q, idle_d;
  logic                      active_q, active_d;
  logic                      in_acc, move_nz, timed_out, load, free;
  logic                      lane_run;
  lane_ctrl_t                lane_ctrl;

  assign in_acc    = in_valid_i && in_ready_o;
  assign move_nz   = (in_word_i.delta_x != '0) || (in_word_i.delta_y != '0);
  assign timed_out = idle_q > IDLE_W'(timeout_q);

  // decode the word: lane op plus idle/active bookkeeping
  always_comb begin
    op_d     = OP_NONE;
    idle_d   = idle_q;
    active_d = active_q;
    if (in_acc) begin
      unique case (in_word_i.cmd)
        CMD_MOVE: begin
          if (move_nz) begin
            op_d     = OP_MOVE;
            idle_d   = '0;
            active_d = 1'b1;
          end
        end
        CMD_TICK: begin
          if (idle_q != IDLE_MAX) begin
            idle_d = idle_q + IDLE_W'(1);
          end
        end
        CMD_POLL: begin
          if (timed_out) begin
            op_d     = OP_DECAY;
            active_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_d == OP_NONE) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    load       = 1'b0;
    lane_run   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  lane_run   = 1'b1;
      ST_DONE: load       = free;
      default: ;
    endcase
  end

  assign lane_ctrl = '{op: op_q, run: lane_run, step: step_q};
  assign step_d = (state_q == ST_RUN && step_q != STEP_LAST) ? step_q + STEP_W'(1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      op_q     <= OP_NONE;
      idle_q   <= '0;
      active_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      idle_q   <= idle_d;
      active_q <= active_d;
      if (in_acc) begin
        op_q <= op_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= in_word_i.delta_x;
      dy_q <= in_word_i.delta_y;
    end
  end

  // Lanes: one per axis
  logic signed [VEL_W-1:0] vel_x, vel_y;

  msas_lane u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .delta_i  (dx_q),
    .sens_i   (sens_x_q),
    .smooth_i (smooth_q),
    .negate_i (1'b0),
    .vel_o    (vel_x)
  );

  msas_lane u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (lane_ctrl),
    .delta_i  (dy_q),
    .sens_i   (sens_y_q),
    .smooth_i (smooth_q),
    .negate_i (invert_q),
    .vel_o    (vel_y)
  );

  msas_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .vel_x_i     (vel_x),
    .vel_y_i     (vel_y),
    .active_i    (active_q),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .free_o      (free)
  );

  // Checks
  a_move_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.cmd == CMD_MOVE && move_nz) |=> (active_q && idle_q == '0))
    else $error("motion did not set active / clear idle count");

  a_decay_clears_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.cmd == CMD_POLL && timed_out) |=> !active_q)
    else $error("timed-out poll left active set");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> (step_q == '0))
    else $error("lane step counter running outside run state");

  a_stick_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.stick_x != 16'sh8000 && out_word_o.stick_y != 16'sh8000))
    else $error("stick value beyond clamp");

endmodule

`default_nettype wire
